// ===== hw/rtl/dpvh_pkg.sv =====
// Shared constants for the depth pixel voxel histogram unit.
package dpvh_pkg;

  // Default geometry and counter size.
  localparam int unsigned CUBE_X_DEF       = 64;
  localparam int unsigned CUBE_Y_DEF       = 64;
  localparam int unsigned CUBE_Z_DEF       = 64;
  localparam int unsigned FRAME_WIDTH_DEF  = 640;
  localparam int unsigned FRAME_HEIGHT_DEF = 480;
  localparam int unsigned COUNT_WIDTH_DEF  = 24;

  // Command codes.
  localparam logic [1:0] CMD_ACCUMULATE = 2'd0;
  localparam logic [1:0] CMD_READ       = 2'd1;
  localparam logic [1:0] CMD_CLEAR      = 2'd2;
  localparam logic [1:0] CMD_RESERVED   = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_ZERO_PLANE    = 3'd0;
  localparam logic [2:0] REG_PIXEL_SCALE   = 3'd1;
  localparam logic [2:0] REG_ROTATION_X    = 3'd2;
  localparam logic [2:0] REG_ROTATION_Y    = 3'd3;
  localparam logic [2:0] REG_ROTATION_Z    = 3'd4;
  localparam logic [2:0] REG_TRANSLATION   = 3'd5;
  localparam logic [2:0] REG_INV_RES       = 3'd6;

  // Register reset values.
  localparam logic [9:0]  ZERO_PLANE_RST   = 10'd120;
  localparam logic [23:0] PIXEL_SCALE_RST  = 24'd29140;
  localparam logic [47:0] ROTATION_X_RST   = 48'd16384;
  localparam logic [47:0] ROTATION_Y_RST   = 48'd1073741824;
  localparam logic [47:0] ROTATION_Z_RST   = 48'd70368744177664;
  localparam logic [59:0] TRANSLATION_RST  = 60'd0;
  localparam logic [23:0] INV_RES_RST      = 24'd3277;

  localparam int unsigned CFG_DATA_W = 60;

endpackage

// ===== hw/rtl/depth_pixel_voxel_histogram_unit.sv =====
// Depth pixel voxel histogram: back-projection datapath and voxel count store.
//
// Input channel (in_valid/in_ready) carries one command item: accumulate a
// depth pixel, read one voxel count, or clear one voxel. Every item gives
// exactly one result item on the output channel (out_valid/out_ready).
// The block works on one item at a time. An accumulate item runs through
// the back-projection stages (z scale, pixel offset, rotation products,
// rounding, voxel scale, range check, linear address) and then a
// read-modify-write of the count memory. Read and clear items go straight
// to the memory steps. The count memory has a registered read and a single
// write port, which set the address and update steps that end every item.
// The result sits in an output register; the next item is accepted while it
// waits. When the receiver stalls, the following item finishes its
// arithmetic and holds before the memory update until the register frees.
// After reset the block sweeps the count memory to zero, one entry a cycle
// (CUBE_X*CUBE_Y*CUBE_Z entries, 262144 by default), and accepts no item
// until the sweep is done. Configuration writes are taken at any time and
// reset to their documented defaults.
module depth_pixel_voxel_histogram_unit #(
  parameter int unsigned CUBE_X       = dpvh_pkg::CUBE_X_DEF,
  parameter int unsigned CUBE_Y       = dpvh_pkg::CUBE_Y_DEF,
  parameter int unsigned CUBE_Z       = dpvh_pkg::CUBE_Z_DEF,
  parameter int unsigned FRAME_WIDTH  = dpvh_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = dpvh_pkg::FRAME_HEIGHT_DEF,
  parameter int unsigned COUNT_WIDTH  = dpvh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      command,
  input  logic [15:0]                     depth_mm,
  input  logic [9:0]                      pixel_column,
  input  logic [8:0]                      pixel_row,
  input  logic [17:0]                     voxel_address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [17:0]                     voxel_index,
  output logic                            voxel_hit,
  output logic [23:0]                     voxel_count,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [dpvh_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned VOXEL_TOTAL = CUBE_X * CUBE_Y * CUBE_Z;
  localparam int unsigned ADDR_W      = $clog2(VOXEL_TOTAL);
  localparam int unsigned CUBE_DIM [3] = '{CUBE_X, CUBE_Y, CUBE_Z};
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ZS, S_XY, S_PROD, S_P8, S_V, S_W, S_LIN, S_ADDR, S_RD
  } state_t;

  typedef enum logic [1:0] {OP_ACC, OP_READ, OP_CLEAR, OP_NONE} op_t;

  state_t state;
  op_t    op;

  // Configuration registers.
  logic [9:0]  zero_plane_mm;
  logic [23:0] pixel_scale;
  logic [47:0] rotation [3];
  logic [59:0] translation_xyz;
  logic [23:0] inverse_resolution;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_plane_mm      <= dpvh_pkg::ZERO_PLANE_RST;
      pixel_scale        <= dpvh_pkg::PIXEL_SCALE_RST;
      rotation[0]        <= dpvh_pkg::ROTATION_X_RST;
      rotation[1]        <= dpvh_pkg::ROTATION_Y_RST;
      rotation[2]        <= dpvh_pkg::ROTATION_Z_RST;
      translation_xyz    <= dpvh_pkg::TRANSLATION_RST;
      inverse_resolution <= dpvh_pkg::INV_RES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpvh_pkg::REG_ZERO_PLANE:   zero_plane_mm      <= cfg_data[9:0];
        dpvh_pkg::REG_PIXEL_SCALE:  pixel_scale        <= cfg_data[23:0];
        dpvh_pkg::REG_ROTATION_X:   rotation[0]        <= cfg_data[47:0];
        dpvh_pkg::REG_ROTATION_Y:   rotation[1]        <= cfg_data[47:0];
        dpvh_pkg::REG_ROTATION_Z:   rotation[2]        <= cfg_data[47:0];
        dpvh_pkg::REG_TRANSLATION:  translation_xyz    <= cfg_data[59:0];
        dpvh_pkg::REG_INV_RES:      inverse_resolution <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Item registers and datapath.
  logic [15:0]              depth;
  logic [9:0]               col;
  logic [8:0]               row;
  logic [17:0]              idx;
  logic                     addr_ok;
  logic [ADDR_W-1:0]        addr;
  logic                     hit;
  logic [16:0]              z;
  logic [40:0]              zs;
  logic signed [39:0]       x10;
  logic signed [39:0]       y10;
  logic signed [55:0]       prod_x [3];
  logic signed [55:0]       prod_y [3];
  logic signed [55:0]       prod_z [3];
  logic signed [41:0]       p8 [3];
  logic signed [66:0]       v [3];
  logic [7:0]               wc [3];
  logic                     in_cube;

  logic signed [12:0]       c2;
  logic signed [12:0]       r2;
  logic signed [55:0]       xp;
  logic signed [55:0]       yp;
  logic signed [27:0]       z10;
  logic signed [57:0]       p24 [3];
  logic signed [66:0]       wsum [3];
  logic signed [42:0]       w [3];
  logic [2:0]               axis_in;
  logic [ADDR_W-1:0]        lin;

  always_comb begin
    c2  = $signed(13'({1'b0, col, 1'b0}) - 13'(FRAME_WIDTH) + 13'd1);
    r2  = $signed(13'({row, 1'b0}) - 13'(FRAME_HEIGHT) + 13'd1);
    xp  = 56'(c2) * 56'($signed({1'b0, zs}));
    yp  = 56'(r2) * 56'($signed({1'b0, zs}));
    z10 = $signed({1'b0, z, 10'b0});
    for (int a = 0; a < 3; a++) begin
      p24[a]  = 58'(prod_x[a]) + 58'(prod_y[a]) + 58'(prod_z[a])
              + (58'($signed(translation_xyz[20*a +: 20])) <<< 24);
      // add half the cube plus one half before the floor
      wsum[a] = v[a] + (67'(CUBE_DIM[a] + 1) <<< 23);
      w[a]    = 43'(wsum[a] >>> 24);
      axis_in[a] = !w[a][42] && (w[a][41:0] < 42'(CUBE_DIM[a]));
    end
    lin = ADDR_W'(wc[2]) * ADDR_W'(CUBE_X * CUBE_Y) + ADDR_W'(wc[1]) * ADDR_W'(CUBE_X)
        + ADDR_W'(wc[0]);
  end

  logic accept;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      depth   <= depth_mm;
      col     <= pixel_column;
      row     <= pixel_row;
      idx     <= voxel_address;
      addr    <= ADDR_W'(voxel_address);
      addr_ok <= 32'(voxel_address) < 32'(VOXEL_TOTAL);
    end
    z      <= 17'(depth) + 17'(zero_plane_mm);
    zs     <= 41'(17'(depth) + 17'(zero_plane_mm)) * 41'(pixel_scale);
    x10    <= 40'((xp + 56'sd16384) >>> 15);
    y10    <= 40'((yp + 56'sd16384) >>> 15);
    for (int a = 0; a < 3; a++) begin
      prod_x[a] <= 56'($signed(rotation[a][15:0])) * 56'(x10);
      prod_y[a] <= 56'($signed(rotation[a][31:16])) * 56'(y10);
      prod_z[a] <= 56'($signed(rotation[a][47:32])) * 56'(z10);
      p8[a]     <= 42'((p24[a] + 58'sd32768) >>> 16);
      v[a]      <= 67'(p8[a]) * 67'($signed({1'b0, inverse_resolution}));
      wc[a]     <= w[a][7:0];
    end
    in_cube <= &axis_in;
    if (state == S_LIN) begin
      addr <= lin;
      idx  <= 18'(lin);
      hit  <= in_cube;
    end
  end

  // Count memory: one write port, one registered read.
  logic [COUNT_WIDTH-1:0] mem [VOXEL_TOTAL];
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [ADDR_W-1:0]      clr_addr;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_wa;
  logic [COUNT_WIDTH-1:0] mem_wd;
  logic                   go;
  logic [COUNT_WIDTH-1:0] inc;

  assign go  = !out_valid || out_ready;
  assign inc = (rd_data == COUNT_MAX) ? COUNT_MAX : rd_data + 1'b1;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr;
    mem_wd = inc;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = '0;
    end else if (state == S_RD && go) begin
      if (op == OP_ACC && hit) begin
        mem_we = 1'b1;
      end else if (op == OP_CLEAR && addr_ok) begin
        mem_we = 1'b1;
        mem_wd = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[addr];
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      op        <= OP_NONE;
    end else begin
      // drop the taken result unless a new one replaces it below
      if (out_valid && out_ready && state != S_RD) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(VOXEL_TOTAL - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (command)
              dpvh_pkg::CMD_ACCUMULATE: begin
                op    <= OP_ACC;
                state <= S_ZS;
              end
              dpvh_pkg::CMD_READ: begin
                op    <= OP_READ;
                state <= S_ADDR;
              end
              dpvh_pkg::CMD_CLEAR: begin
                op    <= OP_CLEAR;
                state <= S_ADDR;
              end
              default: begin
                op    <= OP_NONE;
                state <= S_ADDR;
              end
            endcase
          end
        end
        S_ZS:   state <= S_XY;
        S_XY:   state <= S_PROD;
        S_PROD: state <= S_P8;
        S_P8:   state <= S_V;
        S_V:    state <= S_W;
        S_W:    state <= S_LIN;
        S_LIN:  state <= S_ADDR;
        S_ADDR: state <= S_RD;
        S_RD: begin
          // hold until the result register is free
          if (go) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            unique case (op)
              OP_ACC: begin
                voxel_index <= hit ? idx : '0;
                voxel_hit   <= hit;
                voxel_count <= hit ? 24'(inc) : '0;
              end
              OP_READ, OP_CLEAR: begin
                voxel_index <= idx;
                voxel_hit   <= 1'b0;
                voxel_count <= addr_ok ? 24'(rd_data) : '0;
              end
              OP_NONE: begin
                voxel_index <= '0;
                voxel_hit   <= 1'b0;
                voxel_count <= '0;
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("item accepted while another is in flight");

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !in_ready)
    else $error("item accepted during clearing sweep");

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RD))
    else $error("result raised outside the memory update step");

endmodule

// ===== verif/tb_depth_pixel_voxel_histogram_unit.sv =====
// Self-checking testbench for the depth pixel voxel histogram unit.
`timescale 1ns / 1ps

module tb_depth_pixel_voxel_histogram_unit;

  localparam int unsigned CUBE = 64;
  localparam int unsigned VOXELS = CUBE * CUBE * CUBE;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [17:0] index;
    logic        hit;
    logic [23:0] count;
  } voxel_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic [15:0] depth_mm;
  logic [9:0]  pixel_column;
  logic [8:0]  pixel_row;
  logic [17:0] voxel_address;
  logic        out_valid;
  logic        out_ready;
  logic [17:0] voxel_index;
  logic        voxel_hit;
  logic [23:0] voxel_count;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [dpvh_pkg::CFG_DATA_W-1:0] cfg_data;

  depth_pixel_voxel_histogram_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .depth_mm(depth_mm), .pixel_column(pixel_column),
    .pixel_row(pixel_row), .voxel_address(voxel_address),
    .out_valid(out_valid), .out_ready(out_ready),
    .voxel_index(voxel_index), .voxel_hit(voxel_hit), .voxel_count(voxel_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the configuration and the count store.
  logic [9:0]  mdl_zero_plane;
  logic [23:0] mdl_pixel_scale;
  logic [47:0] mdl_rot_x, mdl_rot_y, mdl_rot_z;
  logic [59:0] mdl_translation;
  logic [23:0] mdl_inv_res;
  int unsigned voxel_tally[int];

  voxel_result_t expected_results[$];
  int            hit_voxels[$];
  int            errors = 0;
  int            items_sent = 0;
  int            results_seen = 0;
  int            hits_seen = 0;
  longint        cycle_count = 0;

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Map one rotated axis to a voxel coordinate; -1 when outside the cube.
  function automatic longint map_axis(logic [47:0] rot, longint x10, longint y10,
                                      longint z10, logic [19:0] offs);
    longint p24, p8, v, w;
    p24 = longint'($signed(rot[15:0])) * x10 + longint'($signed(rot[31:16])) * y10
        + longint'($signed(rot[47:32])) * z10 + (longint'($signed(offs)) <<< 24);
    p8 = (p24 + (64'sd1 <<< 15)) >>> 16;
    v = p8 * longint'(mdl_inv_res);
    w = (v + longint'(CUBE) * (64'sd1 <<< 23) + (64'sd1 <<< 23)) >>> 24;
    return (w < 0 || w >= CUBE) ? -1 : w;
  endfunction

  function automatic voxel_result_t predict_voxel(logic [1:0] cmd, logic [15:0] depth,
                                                  logic [9:0] col, logic [8:0] row,
                                                  logic [17:0] addr);
    voxel_result_t r;
    longint z, c2, r2, zs, x10, y10, wx, wy, wz;
    int unsigned c;
    int lin;
    r = '0;
    if (cmd == dpvh_pkg::CMD_ACCUMULATE) begin
      z = longint'(depth) + longint'(mdl_zero_plane);
      c2 = 2 * longint'(col) - longint'(dpvh_pkg::FRAME_WIDTH_DEF) + 1;
      r2 = 2 * longint'(row) - longint'(dpvh_pkg::FRAME_HEIGHT_DEF) + 1;
      zs = z * longint'(mdl_pixel_scale);
      x10 = (c2 * zs + (64'sd1 <<< 14)) >>> 15;
      y10 = (r2 * zs + (64'sd1 <<< 14)) >>> 15;
      wx = map_axis(mdl_rot_x, x10, y10, z * 1024, mdl_translation[19:0]);
      wy = map_axis(mdl_rot_y, x10, y10, z * 1024, mdl_translation[39:20]);
      wz = map_axis(mdl_rot_z, x10, y10, z * 1024, mdl_translation[59:40]);
      if (wx >= 0 && wy >= 0 && wz >= 0) begin
        lin = int'(wz * CUBE * CUBE + wy * CUBE + wx);
        c = voxel_tally.exists(lin) ? voxel_tally[lin] : 0;
        if (c < 32'hFF_FFFF) c++;
        voxel_tally[lin] = c;
        r.index = lin[17:0];
        r.hit = 1'b1;
        r.count = c[23:0];
        hit_voxels.push_back(lin);
        if (hit_voxels.size() > 32) void'(hit_voxels.pop_front());
      end
    end else if (cmd == dpvh_pkg::CMD_READ || cmd == dpvh_pkg::CMD_CLEAR) begin
      r.index = addr;
      if (addr < VOXELS) begin
        c = voxel_tally.exists(int'(addr)) ? voxel_tally[int'(addr)] : 0;
        r.count = c[23:0];
        if (cmd == dpvh_pkg::CMD_CLEAR) voxel_tally[int'(addr)] = 0;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
             results_seen);
  endtask

  task automatic send_item(logic [1:0] cmd, logic [15:0] depth, logic [9:0] col,
                           logic [8:0] row, logic [17:0] addr);
    @(negedge clk);
    if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    command = cmd;
    depth_mm = depth;
    pixel_column = col;
    pixel_row = row;
    voxel_address = addr;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_voxel(cmd, depth, col, row, addr));
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [dpvh_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      dpvh_pkg::REG_ZERO_PLANE:  mdl_zero_plane = value[9:0];
      dpvh_pkg::REG_PIXEL_SCALE: mdl_pixel_scale = value[23:0];
      dpvh_pkg::REG_ROTATION_X:  mdl_rot_x = value[47:0];
      dpvh_pkg::REG_ROTATION_Y:  mdl_rot_y = value[47:0];
      dpvh_pkg::REG_ROTATION_Z:  mdl_rot_z = value[47:0];
      dpvh_pkg::REG_TRANSLATION: mdl_translation = value[59:0];
      dpvh_pkg::REG_INV_RES:     mdl_inv_res = value[23:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [9:0] rd, logic [23:0] ps, logic [47:0] rx,
                           logic [47:0] ry, logic [47:0] rz, logic [59:0] tr,
                           logic [23:0] ir);
    wait_idle();
    write_reg(dpvh_pkg::REG_ZERO_PLANE, dpvh_pkg::CFG_DATA_W'(rd));
    write_reg(dpvh_pkg::REG_PIXEL_SCALE, dpvh_pkg::CFG_DATA_W'(ps));
    write_reg(dpvh_pkg::REG_ROTATION_X, dpvh_pkg::CFG_DATA_W'(rx));
    write_reg(dpvh_pkg::REG_ROTATION_Y, dpvh_pkg::CFG_DATA_W'(ry));
    write_reg(dpvh_pkg::REG_ROTATION_Z, dpvh_pkg::CFG_DATA_W'(rz));
    write_reg(dpvh_pkg::REG_TRANSLATION, dpvh_pkg::CFG_DATA_W'(tr));
    write_reg(dpvh_pkg::REG_INV_RES, dpvh_pkg::CFG_DATA_W'(ir));
  endtask

  // One random item: mostly near-field pixels that land in the cube, with
  // reads and clears of recently hit voxels and some noise.
  task automatic send_random_item();
    int pick, addr;
    pick = $urandom_range(99);
    addr = $urandom_range(VOXELS * 4 - 1);
    if (hit_voxels.size() > 0 && $urandom_range(3) != 0)
      addr = hit_voxels[$urandom_range(hit_voxels.size() - 1)];
    if (pick < 65)
      send_item(dpvh_pkg::CMD_ACCUMULATE, 16'($urandom_range(520)),
                10'($urandom_range(639)), 9'($urandom_range(479)), 18'($urandom));
    else if (pick < 72)
      send_item(dpvh_pkg::CMD_ACCUMULATE, 16'($urandom), 10'($urandom), 9'($urandom),
                18'($urandom));
    else if (pick < 85)
      send_item(dpvh_pkg::CMD_READ, 16'($urandom), 10'($urandom), 9'($urandom),
                18'(addr));
    else if (pick < 97)
      send_item(dpvh_pkg::CMD_CLEAR, 16'($urandom), 10'($urandom), 9'($urandom),
                18'(addr));
    else
      send_item(dpvh_pkg::CMD_RESERVED, 16'($urandom), 10'($urandom), 9'($urandom),
                18'($urandom));
  endtask

  task automatic test_directed();
    send_item(dpvh_pkg::CMD_ACCUMULATE, 16'd0, 10'd0, 9'd0, 18'd0);
    send_item(dpvh_pkg::CMD_ACCUMULATE, 16'd200, 10'd320, 9'd240, 18'd0);
    send_item(dpvh_pkg::CMD_ACCUMULATE, 16'd200, 10'd320, 9'd240, 18'h3FFFF);
    send_item(dpvh_pkg::CMD_ACCUMULATE, 16'd500, 10'd639, 9'd479, 18'd0);
    send_item(dpvh_pkg::CMD_ACCUMULATE, 16'd500, 10'd0, 9'd479, 18'd0);
    send_item(dpvh_pkg::CMD_ACCUMULATE, 16'hFFFF, 10'd320, 9'd240, 18'd0);
    // pixel outside the frame is used as given
    send_item(dpvh_pkg::CMD_ACCUMULATE, 16'd100, 10'h3FF, 9'h1FF, 18'd0);
    send_item(dpvh_pkg::CMD_ACCUMULATE, 16'd300, 10'd700, 9'd500, 18'd0);
    send_item(dpvh_pkg::CMD_READ, 16'hFFFF, 10'h3FF, 9'h1FF, 18'(hit_voxels[0]));
    send_item(dpvh_pkg::CMD_READ, 16'd0, 10'd0, 9'd0, 18'd0);
    send_item(dpvh_pkg::CMD_READ, 16'd0, 10'd0, 9'd0, 18'h3FFFF);
    send_item(dpvh_pkg::CMD_READ, 16'd0, 10'd0, 9'd0, 18'(VOXELS - 1));
    send_item(dpvh_pkg::CMD_CLEAR, 16'd0, 10'd0, 9'd0, 18'(hit_voxels[0]));
    send_item(dpvh_pkg::CMD_READ, 16'd0, 10'd0, 9'd0, 18'(hit_voxels[0]));
    send_item(dpvh_pkg::CMD_CLEAR, 16'd0, 10'd0, 9'd0, 18'h3FFFF);
    send_item(dpvh_pkg::CMD_CLEAR, 16'd0, 10'd0, 9'd0, 18'(VOXELS));
    send_item(dpvh_pkg::CMD_RESERVED, 16'hFFFF, 10'h3FF, 9'h1FF, 18'h3FFFF);
    send_item(dpvh_pkg::CMD_ACCUMULATE, 16'd200, 10'd320, 9'd240, 18'd0);
  endtask

  task automatic test_config_extremes();
    write_all(10'd0, 24'd0, 48'd0, 48'd0, 48'd0, 60'd0, 24'd0);
    send_item(dpvh_pkg::CMD_ACCUMULATE, 16'hFFFF, 10'h3FF, 9'h1FF, 18'd0);
    send_item(dpvh_pkg::CMD_ACCUMULATE, 16'd0, 10'd0, 9'd0, 18'd0);
    write_all(10'h3FF, 24'hFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h8000_8000_8000,
              48'h7FFF_7FFF_7FFF, 60'hFFF_FFFF_FFFF_FFFF, 24'hFF_FFFF);
    repeat (6) send_item(dpvh_pkg::CMD_ACCUMULATE, 16'($urandom), 10'($urandom),
                         9'($urandom), 18'd0);
    send_item(dpvh_pkg::CMD_ACCUMULATE, 16'hFFFF, 10'h3FF, 9'h1FF, 18'd0);
    // x and z axes negated, translations pushing the cloud back into the cube
    write_all(10'd500, 24'd40000, 48'h0000_0000_C000, 48'h0000_4000_0000,
              48'hC000_0000_0000, {20'd900, 20'hFFF9C, 20'd50}, 24'd4000);
    repeat (10) send_random_item();
    // one-voxel case: inverse resolution 0 maps every point to the center
    write_all(10'd120, 24'd29140, 48'd16384, 48'h0000_4000_0000, 48'h4000_0000_0000,
              60'h800_0080_0008_0000, 24'd0);
    repeat (6) send_random_item();
  endtask

  task automatic test_random(int count, int gap_pct, int stall_pct);
    logic [47:0] rows[3];
    int perm;
    wait_idle();
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    // shifted axes, mostly random signs, small offsets, voxel size near 20 mm
    perm = $urandom_range(2);
    for (int a = 0; a < 3; a++)
      rows[a] = ($urandom_range(1) ? 48'h4000 : 48'hC000) << (16 * ((a + perm) % 3));
    if (perm != 0) rows[2] = 48'h4000_0000_0000;
    write_all(10'($urandom_range(300)), 24'($urandom_range(20000, 40000)),
              rows[0], rows[1], rows[2],
              {20'($urandom_range(400)), 20'($urandom_range(200)),
               20'($urandom_range(200))},
              24'($urandom_range(2500, 4500)));
    repeat (count) send_random_item();
  endtask

  task automatic test_backpressure();
    wait_idle();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    write_all(dpvh_pkg::ZERO_PLANE_RST, dpvh_pkg::PIXEL_SCALE_RST,
              dpvh_pkg::ROTATION_X_RST, dpvh_pkg::ROTATION_Y_RST,
              dpvh_pkg::ROTATION_Z_RST, dpvh_pkg::TRANSLATION_RST,
              dpvh_pkg::INV_RES_RST);
    hold_off_left = 300;
    repeat (25) send_random_item();
  endtask

  // Receiver: long hold-off when asked, random stalls otherwise.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    voxel_result_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("depth_pixel_voxel_histogram_unit test failed");
      $finish;
    end else if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, index", voxel_index, -1);
      end else begin
        want = expected_results.pop_front();
        if (voxel_index !== want.index) report_mismatch("voxel_index", voxel_index,
                                                        want.index);
        if (voxel_hit !== want.hit) report_mismatch("voxel_hit", voxel_hit, want.hit);
        if (voxel_count !== want.count) report_mismatch("voxel_count", voxel_count,
                                                        want.count);
        if (want.hit) hits_seen++;
      end
      results_seen++;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = dpvh_pkg::CMD_ACCUMULATE;
    depth_mm = '0;
    pixel_column = '0;
    pixel_row = '0;
    voxel_address = '0;
    cfg_we = 1'b0;
    cfg_index = dpvh_pkg::REG_ZERO_PLANE;
    cfg_data = '0;
    out_ready = 1'b1;
    mdl_zero_plane = dpvh_pkg::ZERO_PLANE_RST;
    mdl_pixel_scale = dpvh_pkg::PIXEL_SCALE_RST;
    mdl_rot_x = dpvh_pkg::ROTATION_X_RST;
    mdl_rot_y = dpvh_pkg::ROTATION_Y_RST;
    mdl_rot_z = dpvh_pkg::ROTATION_Z_RST;
    mdl_translation = dpvh_pkg::TRANSLATION_RST;
    mdl_inv_res = dpvh_pkg::INV_RES_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_config_extremes();
    test_random(85, 0, 0);
    test_random(85, 71, 0);
    test_random(85, 0, 71);
    test_random(85, 30, 30);
    test_backpressure();
    wait_idle();

    $display("covered %0d items, %0d results, %0d voxel hits", items_sent,
             results_seen, hits_seen);
    $display("register extremes, four idling mixes and a long output hold-off");
    if (errors == 0)
      $display("depth_pixel_voxel_histogram_unit test passed");
    else
      $display("depth_pixel_voxel_histogram_unit test failed");
    $finish;
  end

endmodule
